>>> hw/rtl/sorted_key_slot_table_assert.svh
// Assertion macros for the sorted key slot table.
// Each macro expects a clock i_clk and an active-low reset i_rst_n in scope.
`ifndef SORTED_KEY_SLOT_TABLE_ASSERT_SVH
`define SORTED_KEY_SLOT_TABLE_ASSERT_SVH

// The expression holds at every clock edge outside reset.
`define SKST_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// When the trigger holds, the expression holds in the cycle after.
`define SKST_ASSERT_NEXT(lbl, trig, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (expr)) \
        else $error(msg);

`endif

>>> hw/rtl/skst_pkg.sv
// Package for the sorted key slot table: sizes, codes, state type.
// Used by every module of the block; depends on nothing.
package skst_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int SLOT_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int KEY_W       = 64;

    localparam int IN_TDATA_W  = 144;
    localparam int OUT_TDATA_W = 80;
    localparam int F_SLOT_W    = 6;
    localparam int F_CNT_W     = 7;

    typedef enum logic [2:0] {
        OP_FIND      = 3'd0,
        OP_INSERT    = 3'd1,
        OP_REMOVE    = 3'd2,
        OP_REKEY     = 3'd3,
        OP_READ_RANK = 3'd4
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_FULL      = 3'd3,
        ST_RANGE     = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RANK,
        S_SRCH_KEY,
        S_SRCH_CMP,
        S_SRCH_END,
        S_SHIFT,
        S_PLACE,
        S_RR_KEY,
        S_RR_OUT,
        S_RESULT
    } t_state;

    // Write side of a memory, handed from the sequencer to a RAM.
    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] addr;
    } t_wr_ctl;

endpackage

>>> hw/rtl/skst_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Uses the table package for the write control struct.
module skst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  skst_pkg::t_wr_ctl        i_wr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    import skst_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr[$clog2(DEPTH)-1:0]] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/skst_free_enc.sv
// Lowest free slot finder over the slot occupancy vector.
// Depends on skst_pkg for the table size.
module skst_free_enc (
    input  logic [skst_pkg::MAX_ENTRIES-1:0] i_in_use,
    output logic [skst_pkg::SLOT_W-1:0]      o_slot,
    output logic                             o_found
);
    import skst_pkg::*;

    // Scan from the top so the lowest free slot wins.
    always_comb begin
        o_slot  = '0;
        o_found = 1'b0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            if (!i_in_use[i]) begin
                o_slot  = SLOT_W'(i);
                o_found = 1'b1;
            end
        end
    end

endmodule

>>> hw/rtl/sorted_key_slot_table.sv
// Sorted key slot table: keys in fixed slots plus a rank list sorted by key.
// A binary search runs in halving steps; a shift of the rank list moves one entry per cycle.
// Applications talk to one item stream in and one result stream out.
// Each accepted input item produces exactly one result item. The input item
// carries an opcode, a search key, a replacement key and a rank index.
// The result item carries a status, a slot, a key and the entry count.
// Latency depends on the operation and the table fill. A binary search runs
// each halving step as a rank read, a key read and a compare. Insert and
// remove then shift the rank list one entry per cycle, and rekey does both a
// remove and an insert. Read by rank reads the rank memory, then the key
// memory. One item is in work at a time.
// The input side is ready only while the sequencer is idle. Results sit in
// an output register, so a new item can be taken while the previous result
// still waits for the receiver; when the receiver stalls and the register is
// still full, the finished item waits in the result state.
// Reset (synchronous, active low) empties the table: the count and every
// slot-in-use bit clear. The two memories are not cleared, since only ranks
// below the count are ever read.
module sorted_key_slot_table (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // opcode[2:0], key_hi[34:3], key_lo[66:35], new_key_hi[98:67],
    // new_key_lo[130:99], rank_index[136:131], zero fill above
    input  logic [skst_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // status[2:0], slot[8:3], found_key_hi[40:9], found_key_lo[72:41],
    // entry_count[79:73]
    output logic [skst_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import skst_pkg::*;

    // Input fields.
    logic [2:0]       w_op;
    logic [KEY_W-1:0] w_key;
    logic [KEY_W-1:0] w_nkey;
    logic [5:0]       w_ridx;

    assign w_op   = s_axis_tdata[2:0];
    assign w_key  = {s_axis_tdata[34:3], s_axis_tdata[66:35]};
    assign w_nkey = {s_axis_tdata[98:67], s_axis_tdata[130:99]};
    assign w_ridx = s_axis_tdata[136:131];

    t_state r_state, n_state;

    logic [2:0]             r_op, n_op;
    logic                   r_place, n_place;      // search is for an insert position
    logic [KEY_W-1:0]       r_target, n_target;
    logic [KEY_W-1:0]       r_nkey, n_nkey;
    logic [CNT_W-1:0]       r_lo, n_lo;
    logic [CNT_W-1:0]       r_hi, n_hi;
    logic [SLOT_W-1:0]      r_mid_slot, n_mid_slot;
    logic [SLOT_W-1:0]      r_hit_slot, n_hit_slot;
    logic [KEY_W-1:0]       r_hit_key, n_hit_key;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [MAX_ENTRIES-1:0] r_in_use, n_in_use;
    logic [2:0]             r_res_status, n_res_status;
    logic [SLOT_W-1:0]      r_res_slot, n_res_slot;
    logic [KEY_W-1:0]       r_res_key, n_res_key;
    logic [CNT_W-1:0]       r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]       r_rd_left, n_rd_left;
    logic                   r_wr_pend, n_wr_pend;
    logic [SLOT_W-1:0]      r_wr_addr, n_wr_addr;
    logic                   r_up, n_up;
    logic                   r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_tdata, n_out_tdata;

    logic                   w_accept;
    logic [CNT_W-1:0]       w_mid;
    logic                   w_match;
    logic                   w_out_free;
    logic                   w_shift_done;
    logic [SLOT_W-1:0]      w_free_slot;
    logic                   w_free_found;
    logic                   w_use_ok;

    t_wr_ctl                w_rank_wr, w_key_wr;
    logic [SLOT_W-1:0]      w_rank_wdata, w_rank_raddr, w_rank_q;
    logic [KEY_W-1:0]       w_key_q;
    logic [SLOT_W-1:0]      w_key_raddr;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_mid         = r_lo + ((r_hi - r_lo) >> 1);
    // Upper bound search leaves the last key at or below the target in the hit registers.
    assign w_match       = (r_lo != '0) && (r_hit_key == r_target);
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_shift_done  = (r_rd_left == '0) && !r_wr_pend;
    assign w_use_ok      = ($countones(r_in_use) == 32'(r_count));

    skst_free_enc u_free (
        .i_in_use (r_in_use),
        .o_slot   (w_free_slot),
        .o_found  (w_free_found)
    );

    skst_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_ENTRIES)) u_rank_ram (
        .i_clk   (i_clk),
        .i_wr    (w_rank_wr),
        .i_wdata (w_rank_wdata),
        .i_raddr (w_rank_raddr),
        .o_rdata (w_rank_q)
    );

    skst_ram #(.WIDTH(KEY_W), .DEPTH(MAX_ENTRIES)) u_key_ram (
        .i_clk   (i_clk),
        .i_wr    (w_key_wr),
        .i_wdata (r_target),
        .i_raddr (w_key_raddr),
        .o_rdata (w_key_q)
    );

    // Memory port control.
    always_comb begin
        w_rank_raddr   = '0;
        w_key_raddr    = w_rank_q;
        w_rank_wr.we   = 1'b0;
        w_rank_wr.addr = r_wr_addr;
        w_rank_wdata   = w_rank_q;
        w_key_wr.we    = 1'b0;
        w_key_wr.addr  = r_res_slot;
        case (r_state)
            S_IDLE: begin
                w_rank_raddr = SLOT_W'(w_ridx);
            end
            S_SRCH_RANK: begin
                w_rank_raddr = w_mid[SLOT_W-1:0];
            end
            S_SHIFT: begin
                w_rank_raddr = r_rd_ptr[SLOT_W-1:0];
                w_rank_wr.we = r_wr_pend;
            end
            S_PLACE: begin
                w_rank_wr.we   = 1'b1;
                w_rank_wr.addr = r_lo[SLOT_W-1:0];
                w_rank_wdata   = r_res_slot;
                w_key_wr.we    = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_op == OP_READ_RANK && CNT_W'(w_ridx) < r_count) begin
                        n_state = S_RR_KEY;
                    end else if ((w_op inside {OP_FIND, OP_REMOVE, OP_REKEY})
                                 && r_count != '0) begin
                        n_state = S_SRCH_RANK;
                    end else if (w_op == OP_INSERT && r_count < CNT_W'(MAX_ENTRIES)
                                 && w_free_found) begin
                        n_state = S_SRCH_RANK;
                    end else begin
                        n_state = S_RESULT;
                    end
                end
            end
            S_SRCH_RANK: n_state = (r_lo < r_hi) ? S_SRCH_KEY : S_SRCH_END;
            S_SRCH_KEY:  n_state = S_SRCH_CMP;
            S_SRCH_CMP:  n_state = S_SRCH_RANK;
            S_SRCH_END: begin
                if (r_place) begin
                    n_state = S_SHIFT;
                end else if (!w_match || r_op == OP_FIND) begin
                    n_state = S_RESULT;
                end else begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (w_shift_done) begin
                    if (r_up) begin
                        n_state = S_PLACE;
                    end else if (r_op == OP_REKEY) begin
                        n_state = S_SRCH_RANK;
                    end else begin
                        n_state = S_RESULT;
                    end
                end
            end
            S_PLACE:  n_state = S_RESULT;
            S_RR_KEY: n_state = S_RR_OUT;
            S_RR_OUT: n_state = S_RESULT;
            S_RESULT: n_state = w_out_free ? S_IDLE : S_RESULT;
            default:  n_state = S_IDLE;
        endcase
    end

    // Datapath registers.
    always_comb begin
        n_op         = r_op;
        n_place      = r_place;
        n_target     = r_target;
        n_nkey       = r_nkey;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid_slot   = r_mid_slot;
        n_hit_slot   = r_hit_slot;
        n_hit_key    = r_hit_key;
        n_count      = r_count;
        n_in_use     = r_in_use;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_res_key    = r_res_key;
        n_rd_ptr     = r_rd_ptr;
        n_rd_left    = r_rd_left;
        n_wr_pend    = r_wr_pend;
        n_wr_addr    = r_wr_addr;
        n_up         = r_up;
        n_out_valid  = r_out_valid;
        n_out_tdata  = r_out_tdata;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op         = w_op;
                    n_target     = w_key;
                    n_nkey       = w_nkey;
                    n_lo         = '0;
                    n_hi         = r_count;
                    n_res_status = ST_OK;
                    n_res_slot   = '0;
                    n_res_key    = '0;
                    n_place      = 1'b0;
                    case (w_op)
                        OP_FIND, OP_REMOVE, OP_REKEY: begin
                            if (r_count == '0) begin
                                n_res_status = ST_EMPTY;
                            end
                        end
                        OP_INSERT: begin
                            if (r_count >= CNT_W'(MAX_ENTRIES) || !w_free_found) begin
                                n_res_status = ST_FULL;
                            end else begin
                                n_place    = 1'b1;
                                n_res_slot = w_free_slot;
                                n_res_key  = w_key;
                            end
                        end
                        OP_READ_RANK: begin
                            if (CNT_W'(w_ridx) >= r_count) begin
                                n_res_status = ST_RANGE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SRCH_KEY: begin
                n_mid_slot = w_rank_q;
            end
            S_SRCH_CMP: begin
                if (w_key_q <= r_target) begin
                    n_lo       = w_mid + CNT_W'(1);
                    n_hit_slot = r_mid_slot;
                    n_hit_key  = w_key_q;
                end else begin
                    n_hi = w_mid;
                end
            end
            S_SRCH_END: begin
                n_up      = r_place;
                n_wr_pend = 1'b0;
                n_rd_left = r_count - r_lo;
                if (r_place) begin
                    n_rd_ptr = r_count - CNT_W'(1);
                end else if (!w_match) begin
                    n_res_status = ST_NOT_FOUND;
                end else begin
                    // Rank of the match is lo - 1; the entries above it move down.
                    n_res_slot = r_hit_slot;
                    n_res_key  = r_target;
                    n_rd_ptr   = r_lo;
                end
            end
            S_SHIFT: begin
                n_wr_pend = (r_rd_left != '0);
                if (r_rd_left != '0) begin
                    n_rd_left = r_rd_left - CNT_W'(1);
                    if (r_up) begin
                        n_wr_addr = r_rd_ptr[SLOT_W-1:0] + SLOT_W'(1);
                        n_rd_ptr  = r_rd_ptr - CNT_W'(1);
                    end else begin
                        n_wr_addr = r_rd_ptr[SLOT_W-1:0] - SLOT_W'(1);
                        n_rd_ptr  = r_rd_ptr + CNT_W'(1);
                    end
                end
                if (w_shift_done && !r_up) begin
                    n_count = r_count - CNT_W'(1);
                    if (r_op == OP_REKEY) begin
                        n_target  = r_nkey;
                        n_res_key = r_nkey;
                        n_place   = 1'b1;
                        n_lo      = '0;
                        n_hi      = r_count - CNT_W'(1);
                    end else begin
                        n_in_use[r_res_slot] = 1'b0;
                    end
                end
            end
            S_PLACE: begin
                n_count              = r_count + CNT_W'(1);
                n_in_use[r_res_slot] = 1'b1;
            end
            S_RR_KEY: begin
                n_res_slot = w_rank_q;
            end
            S_RR_OUT: begin
                n_res_key = w_key_q;
            end
            S_RESULT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_tdata = {F_CNT_W'(r_count), r_res_key[31:0], r_res_key[63:32],
                                   F_SLOT_W'(r_res_slot), r_res_status};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_in_use    <= '0;
            r_out_valid <= 1'b0;
            r_wr_pend   <= 1'b0;
            r_rd_left   <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_in_use    <= n_in_use;
            r_out_valid <= n_out_valid;
            r_wr_pend   <= n_wr_pend;
            r_rd_left   <= n_rd_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_place      <= n_place;
        r_target     <= n_target;
        r_nkey       <= n_nkey;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_mid_slot   <= n_mid_slot;
        r_hit_slot   <= n_hit_slot;
        r_hit_key    <= n_hit_key;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_res_key    <= n_res_key;
        r_rd_ptr     <= n_rd_ptr;
        r_wr_addr    <= n_wr_addr;
        r_up         <= n_up;
        r_out_tdata  <= n_out_tdata;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_tdata;

`include "sorted_key_slot_table_assert.svh"

    `SKST_ASSERT_ALWAYS(a_count_range, r_count <= CNT_W'(MAX_ENTRIES), "entry count overflow")
    `SKST_ASSERT_ALWAYS(a_use_matches_count, (r_state != S_IDLE) || w_use_ok, "use bits vs count")
    `SKST_ASSERT_NEXT(a_accept_leaves_idle, w_accept, r_state != S_IDLE, "item did not start")
    `SKST_ASSERT_ALWAYS(a_shift_write_owned, !r_wr_pend || (r_state == S_SHIFT), "stray write")

endmodule
